// ----- hdl/sllc_pkg.sv -----
// ----------------------------------------------------------------------------
// sllc_pkg
// Shared command codes for the linked list with cursor block.
// ----------------------------------------------------------------------------
package sllc_pkg;

	localparam int CMD_W = 4;
	localparam int VAL_W = 32;

	typedef logic [CMD_W-1:0]        cmd_t;
	typedef logic signed [VAL_W-1:0] val_t;

	localparam cmd_t CMD_CLEAR     = 4'd0;
	localparam cmd_t CMD_INS_HEAD  = 4'd1;
	localparam cmd_t CMD_CUR_HEAD  = 4'd2;
	localparam cmd_t CMD_DEL_HEAD  = 4'd3;
	localparam cmd_t CMD_DEL_AFTER = 4'd4;
	localparam cmd_t CMD_INS_AFTER = 4'd5;
	localparam cmd_t CMD_OVERWRITE = 4'd6;
	localparam cmd_t CMD_ADVANCE   = 4'd7;
	localparam cmd_t CMD_QUERY     = 4'd8;

endpackage

// ----- hdl/sllc_ram.sv -----
// ----------------------------------------------------------------------------
// sllc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sllc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/singly_linked_list_with_cursor_core.sv -----
// ----------------------------------------------------------------------------
// singly_linked_list_with_cursor_core
// Singly linked list of signed values with an active cursor over a node pool.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command and a value per
//   transaction. Output channel (out_valid/out_ready) returns one result per
//   command: head value/valid, cursor value/active, status, sticky error.
//   Node values and links live in two RAMs with registered read; the
//   head and cursor values are also shadowed in registers.
//   One command at a time. Clear, cursor to head, overwrite, query, insert
//   at head and any no-op pass through RD1 and FIN; delete head leaving a
//   new head node or advance onto a node (link read, then value read) and
//   a refused insert after cursor pass through RD1, RD2 and FIN; delete
//   after or insert after that change the list also pass RD3 before FIN
//   (chained link reads, two link writes). FIN loads the result register.
//   The result register frees the sequencer: a new command is taken while a
//   result waits; a command finishing while the output is still stalled
//   holds in its final state until the result register empties.
//   Reset empties the list and pool and clears the sticky error. RAM
//   contents are not cleared; only reachable nodes are ever read.
// ----------------------------------------------------------------------------
module singly_linked_list_with_cursor_core
	import sllc_pkg::*;
#(
	parameter int POOL_NODES = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// command channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CMD_W-1:0]        cmd,
	input  logic signed [VAL_W-1:0] value,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] first_value,
	output logic                    first_valid,
	output logic signed [VAL_W-1:0] cursor_value,
	output logic                    cursor_active,
	output logic                    status,
	output logic                    error_seen
);

	// pointer width includes the nil code (POOL_NODES)
	localparam int IW = $clog2(POOL_NODES);
	localparam int PW = $clog2(POOL_NODES + 1);
	localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD1  = 3'd1;
	localparam logic [2:0] ST_RD2  = 3'd2;
	localparam logic [2:0] ST_RD3  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	function automatic logic is_node(input logic [PW-1:0] p);
		is_node = (p < NIL);
	endfunction

	function automatic logic [IW-1:0] idx(input logic [PW-1:0] p);
		idx = p[IW-1:0];
	endfunction

	// control state
	logic [2:0]    state_q, state_d;
	logic [PW-1:0] head_q, head_d;
	logic [PW-1:0] cursor_q, cursor_d;
	logic [PW-1:0] free_q, free_d;     // top of free stack
	logic [PW-1:0] fresh_q, fresh_d;   // bump counter of never-used nodes
	logic          sticky_q, sticky_d;
	val_t          head_val_q, head_val_d;
	val_t          cur_val_q, cur_val_d;
	logic          out_valid_q, out_valid_d;

	// per-command working registers
	cmd_t          cmd_q, cmd_d;
	val_t          val_q, val_d;
	logic          status_q, status_d;
	logic [PW-1:0] ta_q, ta_d;
	logic [PW-1:0] tb_q, tb_d;

	// result register
	val_t          first_value_q, cursor_value_q;
	logic          first_valid_q, cursor_active_q, status_out_q, error_q;
	logic          load_out;

	// RAM ports
	logic          link_we, val_we;
	logic [IW-1:0] link_waddr, val_waddr, link_raddr, val_raddr;
	logic [PW-1:0] link_wdata, link_rdata;
	logic [VAL_W-1:0] val_wdata, val_rdata;

	sllc_ram #(
		.WIDTH (PW),
		.DEPTH (POOL_NODES)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (1'b1),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	sllc_ram #(
		.WIDTH (VAL_W),
		.DEPTH (POOL_NODES)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.re    (1'b1),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		cursor_d    = cursor_q;
		free_d      = free_q;
		fresh_d     = fresh_q;
		sticky_d    = sticky_q;
		head_val_d  = head_val_q;
		cur_val_d   = cur_val_q;
		out_valid_d = out_valid_q;
		cmd_d       = cmd_q;
		val_d       = val_q;
		status_d    = status_q;
		ta_d        = ta_q;
		tb_d        = tb_q;
		load_out    = 1'b0;
		link_we     = 1'b0;
		link_waddr  = idx(cursor_q);
		link_wdata  = tb_q;
		link_raddr  = idx(cursor_q);
		val_we      = 1'b0;
		val_waddr   = idx(cursor_q);
		val_wdata   = val_q;
		val_raddr   = idx(link_rdata);

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_d    = cmd;
					val_d    = value;
					status_d = 1'b0;
					state_d  = ST_RD1;
					// first link read issued along with the transaction
					case (cmd)
						CMD_INS_HEAD: link_raddr = idx(free_q);
						CMD_DEL_HEAD: link_raddr = idx(head_q);
						default:      link_raddr = idx(cursor_q);
					endcase
				end
			end

			ST_RD1: begin
				state_d = ST_FIN;
				case (cmd_q)
					CMD_CLEAR: begin
						head_d     = NIL;
						cursor_d   = NIL;
						free_d     = NIL;
						fresh_d    = '0;
						head_val_d = '0;
						cur_val_d  = '0;
					end
					CMD_INS_HEAD: begin
						if (is_node(free_q) || fresh_q < NIL) begin
							if (is_node(free_q)) begin
								ta_d   = free_q;
								free_d = link_rdata;
							end else begin
								ta_d    = fresh_q;
								fresh_d = fresh_q + 1'b1;
							end
							val_we     = 1'b1;
							val_waddr  = is_node(free_q) ? idx(free_q) : idx(fresh_q);
							val_wdata  = val_q;
							link_we    = 1'b1;
							link_waddr = is_node(free_q) ? idx(free_q) : idx(fresh_q);
							link_wdata = head_q;
							head_d     = is_node(free_q) ? free_q : fresh_q;
							head_val_d = val_q;
						end else begin
							status_d = 1'b1;
						end
					end
					CMD_CUR_HEAD: begin
						cursor_d  = head_q;
						cur_val_d = head_val_q;
					end
					CMD_DEL_HEAD: begin
						if (is_node(head_q)) begin
							// push old head on the free stack
							link_we    = 1'b1;
							link_waddr = idx(head_q);
							link_wdata = free_q;
							free_d     = head_q;
							if (cursor_q == head_q) begin
								cursor_d  = NIL;
								cur_val_d = '0;
							end
							head_d = link_rdata;
							if (is_node(link_rdata)) begin
								val_raddr = idx(link_rdata);
								state_d   = ST_RD2;
							end else begin
								head_val_d = '0;
							end
						end
					end
					CMD_DEL_AFTER: begin
						if (is_node(cursor_q) && is_node(link_rdata)) begin
							ta_d       = link_rdata;
							link_raddr = idx(link_rdata);
							state_d    = ST_RD2;
						end
					end
					CMD_INS_AFTER: begin
						if (is_node(cursor_q)) begin
							tb_d       = link_rdata;
							link_raddr = idx(free_q);
							state_d    = ST_RD2;
						end
					end
					CMD_OVERWRITE: begin
						if (is_node(cursor_q)) begin
							val_we    = 1'b1;
							val_waddr = idx(cursor_q);
							val_wdata = val_q;
							cur_val_d = val_q;
							if (cursor_q == head_q) begin
								head_val_d = val_q;
							end
						end
					end
					CMD_ADVANCE: begin
						if (is_node(cursor_q)) begin
							cursor_d = link_rdata;
							if (is_node(link_rdata)) begin
								val_raddr = idx(link_rdata);
								state_d   = ST_RD2;
							end else begin
								cur_val_d = '0;
							end
						end
					end
					default: begin
					end
				endcase
			end

			ST_RD2: begin
				state_d = ST_FIN;
				case (cmd_q)
					CMD_DEL_HEAD: begin
						head_val_d = val_rdata;
					end
					CMD_DEL_AFTER: begin
						// victim goes on the free stack, its successor kept
						link_we    = 1'b1;
						link_waddr = idx(ta_q);
						link_wdata = free_q;
						free_d     = ta_q;
						tb_d       = link_rdata;
						state_d    = ST_RD3;
					end
					CMD_INS_AFTER: begin
						if (is_node(free_q) || fresh_q < NIL) begin
							if (is_node(free_q)) begin
								ta_d   = free_q;
								free_d = link_rdata;
							end else begin
								ta_d    = fresh_q;
								fresh_d = fresh_q + 1'b1;
							end
							val_we     = 1'b1;
							val_waddr  = is_node(free_q) ? idx(free_q) : idx(fresh_q);
							val_wdata  = val_q;
							link_we    = 1'b1;
							link_waddr = is_node(free_q) ? idx(free_q) : idx(fresh_q);
							link_wdata = tb_q;
							state_d    = ST_RD3;
						end else begin
							status_d = 1'b1;
						end
					end
					CMD_ADVANCE: begin
						cur_val_d = val_rdata;
					end
					default: begin
					end
				endcase
			end

			ST_RD3: begin
				// relink the cursor node
				link_we    = 1'b1;
				link_waddr = idx(cursor_q);
				link_wdata = (cmd_q == CMD_DEL_AFTER) ? tb_q : ta_q;
				state_d    = ST_FIN;
			end

			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out    = 1'b1;
					out_valid_d = 1'b1;
					sticky_d    = sticky_q | status_q;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= NIL;
			cursor_q    <= NIL;
			free_q      <= NIL;
			fresh_q     <= '0;
			sticky_q    <= 1'b0;
			head_val_q  <= '0;
			cur_val_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			cursor_q    <= cursor_d;
			free_q      <= free_d;
			fresh_q     <= fresh_d;
			sticky_q    <= sticky_d;
			head_val_q  <= head_val_d;
			cur_val_q   <= cur_val_d;
			out_valid_q <= out_valid_d;
		end
	end

	// working and result payload, no reset needed
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		val_q    <= val_d;
		status_q <= status_d;
		ta_q     <= ta_d;
		tb_q     <= tb_d;
		if (load_out) begin
			first_value_q   <= is_node(head_q) ? head_val_q : '0;
			first_valid_q   <= is_node(head_q);
			cursor_value_q  <= is_node(cursor_q) ? cur_val_q : '0;
			cursor_active_q <= is_node(cursor_q);
			status_out_q    <= status_q;
			error_q         <= sticky_q | status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign first_value   = first_value_q;
	assign first_valid   = first_valid_q;
	assign cursor_value  = cursor_value_q;
	assign cursor_active = cursor_active_q;
	assign status        = status_out_q;
	assign error_seen    = error_q;

endmodule
